// ===== design/hrwl_pkg.sv =====
// Shared types, constants and a helper function of the hex record word loader.
`default_nettype none

package hrwl_pkg;

  // Default queue sizes, as address widths (depth is a power of two).
  localparam int TOK_AW_DEF = 2;
  localparam int RES_AW_DEF = 2;

  // Character and record type codes.
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_TEN  = 8'd10;

  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;
  localparam logic [7:0] REC_BASE = 8'd4;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Record parser phases.
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_LEN  = 3'd1,
    PH_OFS  = 3'd2,
    PH_TYPE = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5
  } phase_t;

  // One classified character as handed from the front to the back.
  typedef struct packed {
    logic       colon;
    logic [3:0] nib;
  } tok_t;

  // One result item.
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] addr;
    logic        kind;
  } res_t;

  // Hex digit value; any other character counts as (c - '0') mod 16.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    begin
      if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
        v = c - CHAR_UC_A + DIGIT_TEN;
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
        v = c - CHAR_LC_A + DIGIT_TEN;
      end else begin
        v = c - CHAR_ZERO;
      end
      return v[3:0];
    end
  endfunction

endpackage : hrwl_pkg

`default_nettype wire

// ===== design/hrwl_fifo.sv =====
// Small first-in first-out queue used between the loader's parts.
`default_nettype none

module hrwl_fifo
  import hrwl_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int AW    = TOK_AW_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write; entries need no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule : hrwl_fifo

`default_nettype wire

// ===== design/hrwl_front.sv =====
// Front part: accepts characters and classifies them into colon marks and nibbles.
`default_nettype none

module hrwl_front
  import hrwl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_char_in,
  output logic            tok_push,
  output tok_t            tok_data,
  input  wire logic       tok_full
);

  logic tok_vld_r, tok_vld_nxt;
  tok_t tok_r;
  logic accept;

  // The stage holds one token; it frees up whenever the queue takes it.
  assign full     = tok_vld_r && tok_full;
  assign accept   = push && !full;
  assign tok_push = tok_vld_r && !tok_full;
  assign tok_data = tok_r;

  always_comb begin
    tok_vld_nxt = tok_vld_r;
    if (accept) begin
      tok_vld_nxt = 1'b1;
    end else if (tok_push) begin
      tok_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_nxt;
    end
  end

  // Classify the character on each transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      tok_r.colon <= (in_char_in == CHAR_COLON);
      tok_r.nib   <= nibble_of(in_char_in);
    end
  end

endmodule : hrwl_front

`default_nettype wire

// ===== design/hrwl_back.sv =====
// Back part: record parser that pairs nibbles into bytes and builds result words.
`default_nettype none

module hrwl_back
  import hrwl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tok_t tok_data,
  input  wire logic tok_empty,
  output logic      tok_pop,
  output logic      res_push,
  output res_t      res_data,
  input  wire logic res_full
);

  phase_t       phase_r, phase_nxt;
  logic [3:0]   hi_nib_r, hi_nib_nxt;
  logic         toggle_r, toggle_nxt;
  logic [7:0]   rec_len_r, rec_len_nxt;
  logic [15:0]  rec_ofs_r, rec_ofs_nxt;
  logic [7:0]   rec_type_r, rec_type_nxt;
  logic [7:0]   byte_cnt_r, byte_cnt_nxt;
  logic [23:0]  group_r, group_nxt;
  logic [15:0]  base_r, base_nxt;
  logic         finished_r, finished_nxt;
  logic         take;
  logic         emit;
  logic [7:0]   b;
  logic [1:0]   lane;
  logic         last;
  logic [23:0]  group_ins;

  // A token is consumed whenever the result queue has room.
  assign take    = !tok_empty && !res_full;
  assign tok_pop = take;
  assign res_push = take && emit;

  assign b         = {hi_nib_r, tok_data.nib};
  assign lane      = byte_cnt_r[1:0];
  assign last      = ({1'b0, byte_cnt_r} + 9'd1) >= {1'b0, rec_len_r};
  assign group_ins = (lane == 2'd0) ? {group_r[23:8], b} :
                     (lane == 2'd1) ? {group_r[23:16], b, group_r[7:0]} :
                                      {b, group_r[15:0]};

  // Parser next state and result formation.
  always_comb begin
    phase_nxt    = phase_r;
    hi_nib_nxt   = hi_nib_r;
    toggle_nxt   = toggle_r;
    rec_len_nxt  = rec_len_r;
    rec_ofs_nxt  = rec_ofs_r;
    rec_type_nxt = rec_type_r;
    byte_cnt_nxt = byte_cnt_r;
    group_nxt    = group_r;
    base_nxt     = base_r;
    finished_nxt = finished_r;
    emit         = 1'b0;
    res_data     = '{word: 32'd0, addr: 32'd0, kind: KIND_WORD};

    if (take && !finished_r) begin
      if (phase_r == PH_WAIT) begin
        if (tok_data.colon) begin
          phase_nxt    = PH_LEN;
          toggle_nxt   = 1'b0;
          hi_nib_nxt   = 4'd0;
          byte_cnt_nxt = 8'd0;
          group_nxt    = 24'd0;
        end
      end else if (!toggle_r) begin
        hi_nib_nxt = tok_data.nib;
        toggle_nxt = 1'b1;
      end else begin
        toggle_nxt = 1'b0;
        unique case (phase_r)
          PH_LEN: begin
            rec_len_nxt  = b;
            rec_ofs_nxt  = 16'd0;
            byte_cnt_nxt = 8'd0;
            phase_nxt    = PH_OFS;
          end
          PH_OFS: begin
            rec_ofs_nxt = {rec_ofs_r[7:0], b};
            if (byte_cnt_r[0]) begin
              byte_cnt_nxt = 8'd0;
              phase_nxt    = PH_TYPE;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 8'd1;
            end
          end
          PH_TYPE: begin
            rec_type_nxt = b;
            byte_cnt_nxt = 8'd0;
            group_nxt    = 24'd0;
            if (b == REC_EOF) begin
              emit          = 1'b1;
              res_data.kind = KIND_EOF;
              finished_nxt  = 1'b1;
              phase_nxt     = PH_WAIT;
            end else begin
              if (b == REC_BASE) begin
                base_nxt = 16'd0;
              end
              phase_nxt = (rec_len_r == 8'd0) ? PH_SUM : PH_DATA;
            end
          end
          PH_DATA: begin
            if (rec_type_r == REC_DATA) begin
              if (lane != 2'd3) begin
                group_nxt = group_ins;
              end
              if (lane == 2'd3 || last) begin
                emit          = 1'b1;
                res_data.word = (lane == 2'd3) ? {b, group_r} : {8'd0, group_ins};
                res_data.addr = {base_r, rec_ofs_r};
                group_nxt     = 24'd0;
              end
            end else if (rec_type_r == REC_BASE) begin
              base_nxt = {base_r[7:0], b};
            end
            byte_cnt_nxt = byte_cnt_r + 8'd1;
            if (last) begin
              phase_nxt = PH_SUM;
            end
          end
          PH_SUM: begin
            phase_nxt = PH_WAIT;
          end
          default: begin
            phase_nxt = PH_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      hi_nib_r   <= 4'd0;
      toggle_r   <= 1'b0;
      rec_len_r  <= 8'd0;
      rec_ofs_r  <= 16'd0;
      rec_type_r <= 8'd0;
      byte_cnt_r <= 8'd0;
      group_r    <= 24'd0;
      base_r     <= 16'd0;
      finished_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hi_nib_r   <= hi_nib_nxt;
      toggle_r   <= toggle_nxt;
      rec_len_r  <= rec_len_nxt;
      rec_ofs_r  <= rec_ofs_nxt;
      rec_type_r <= rec_type_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      group_r    <= group_nxt;
      base_r     <= base_nxt;
      finished_r <= finished_nxt;
    end
  end

  // Once the end record is seen, no further result is produced.
  a_no_res_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !res_push)
    else $error("result produced after end record");

  // An end result carries zero word and address and finishes the parser.
  a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_data.kind == KIND_EOF) |->
      (res_data.word == 32'd0 && res_data.addr == 32'd0) ##1 finished_r)
    else $error("malformed end result");

  // The offset phase never counts past its second byte.
  a_ofs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OFS) |-> (byte_cnt_r < 8'd2))
    else $error("offset byte count out of range");

  // Results are only pushed while the token queue is being drained.
  a_push_with_pop: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (tok_pop && !res_full))
    else $error("result pushed without a token transfer");

endmodule : hrwl_back

`default_nettype wire

// ===== design/hex_record_word_loader.sv =====
// Top level of the hex record word loader: front, token queue, back, result queue.
//
//  Channel   Handshake            Payload
//  input     push / full          in_char_in[7:0]
//  result    empty / pop          out_word_out[31:0], out_word_addr[31:0], out_kind
//
//  One character is taken per cycle while full is low. A character passes
//  through the classify register, the token queue and the result queue in
//  that order; the result queue drives the output ports combinationally.
//  Reset (rst_n low, synchronous) empties both queues and returns the parser
//  to waiting for a colon with a zero base.
//  A stalled result side fills the result queue, then the token queue, then
//  raises full; each queue holds 2**AW items.
`default_nettype none

module hex_record_word_loader
  import hrwl_pkg::*;
#(
  parameter int TOK_AW = TOK_AW_DEF,
  parameter int RES_AW = RES_AW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_in,
  output logic             empty,
  input  wire logic        pop,
  output logic      [31:0] out_word_out,
  output logic      [31:0] out_word_addr,
  output logic             out_kind
);

  tok_t fr_tok;
  tok_t bk_tok;
  logic fr_push, tq_full, tq_empty, bk_pop;
  res_t bk_res, rq_res;
  logic bk_push, rq_full;

  // Character classification.
  hrwl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_char_in (in_char_in),
    .tok_push   (fr_push),
    .tok_data   (fr_tok),
    .tok_full   (tq_full)
  );

  // Queue of classified characters.
  hrwl_fifo #(
    .WIDTH ($bits(tok_t)),
    .AW    (TOK_AW)
  ) u_tok_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_push),
    .wr_data (fr_tok),
    .full    (tq_full),
    .rd_en   (bk_pop),
    .rd_data (bk_tok),
    .empty   (tq_empty)
  );

  // Record parser.
  hrwl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_data  (bk_tok),
    .tok_empty (tq_empty),
    .tok_pop   (bk_pop),
    .res_push  (bk_push),
    .res_data  (bk_res),
    .res_full  (rq_full)
  );

  // Queue of finished results, presented on the output ports.
  hrwl_fifo #(
    .WIDTH ($bits(res_t)),
    .AW    (RES_AW)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bk_push),
    .wr_data (bk_res),
    .full    (rq_full),
    .rd_en   (pop),
    .rd_data (rq_res),
    .empty   (empty)
  );

  assign out_word_out  = rq_res.word;
  assign out_word_addr = rq_res.addr;
  assign out_kind      = rq_res.kind;

endmodule : hex_record_word_loader

`default_nettype wire
